>>> sv/rtd_pkg.sv
// Shared types and constants for the run-length raster decoder.
`default_nettype none

package rtd_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MIN_WIDTH = 32;
    localparam int HEADER_WORDS  = 7;

    localparam int WORD_W  = 16;
    localparam int RUN_W   = 8;
    localparam int POS_W   = 10;
    localparam int WIDTH_W = 11;
    localparam int IDX_W   = 3;
    localparam int COLOR_W = 2;

    localparam logic [POS_W-1:0] MAX_ROW = '1;

    // header word numbers that carry settings
    localparam logic [IDX_W-1:0] HDR_WIDTH      = 3'd3;
    localparam logic [IDX_W-1:0] HDR_RUN_WIDTHS = 3'd5;
    localparam logic [IDX_W-1:0] HDR_RED_WIDTH  = 3'd6;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_SEGMENT = 1'b1;

    localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd2;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_PAINT
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_hdr;
        logic emit_seg;
    } t_cmd;

    typedef struct packed {
        logic hdr_next;
        logic any_run;
        logic seg_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> sv/rtd_ctrl.sv
// Controller state machine: sequences request intake, header echo and segment painting.
`default_nettype none

module rtd_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_stall,
    input  rtd_pkg::t_sts i_sts,
    output rtd_pkg::t_cmd o_cmd
);
    import rtd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.hdr_next ? S_HEAD : S_PAINT;
                end
            end
            S_HEAD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_hdr = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_PAINT: begin
                // drop a word whose runs are all empty
                if (!i_sts.any_run) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_seg = 1'b1;
                    if (i_sts.seg_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/rtd_datapath.sv
// Datapath: header capture, run extraction, raster position and output register.
`default_nettype none

module rtd_datapath #(
    parameter int MAX_WIDTH = rtd_pkg::DEF_MAX_WIDTH,
    parameter int MIN_WIDTH = rtd_pkg::DEF_MIN_WIDTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  [rtd_pkg::WORD_W-1:0]          i_data_word,
    input  wire                                 i_start_image,
    input  wire                                 i_stall,
    input  rtd_pkg::t_cmd                       i_cmd,
    output rtd_pkg::t_sts                       o_sts,
    output logic                                o_valid,
    output logic                                o_kind,
    output logic [rtd_pkg::IDX_W-1:0]           o_header_index,
    output logic [rtd_pkg::WORD_W-1:0]          o_header_value,
    output logic [rtd_pkg::COLOR_W-1:0]         o_pixel_color,
    output logic [rtd_pkg::POS_W-1:0]           o_seg_x,
    output logic [rtd_pkg::POS_W-1:0]           o_seg_y,
    output logic [rtd_pkg::RUN_W-1:0]           o_seg_len,
    output logic                                o_last
);
    import rtd_pkg::*;

    localparam logic [WIDTH_W-1:0] W_MIN = WIDTH_W'(MIN_WIDTH);
    localparam logic [WIDTH_W-1:0] W_MAX = WIDTH_W'(MAX_WIDTH);

    logic [IDX_W-1:0]   r_wc;
    logic [WIDTH_W-1:0] r_width;
    logic [3:0]         r_bshift;
    logic [3:0]         r_rbits;
    logic [POS_W-1:0]   r_col;
    logic [POS_W-1:0]   r_row;
    logic [RUN_W-1:0]   r_run [3];
    logic [IDX_W-1:0]   r_hidx;
    logic [WORD_W-1:0]  r_word;

    logic               r_ovalid;
    logic               r_okind;
    logic [IDX_W-1:0]   r_ohidx;
    logic [WORD_W-1:0]  r_oword;
    logic [COLOR_W-1:0] r_ocolor;
    logic [POS_W-1:0]   r_ox;
    logic [POS_W-1:0]   r_oy;
    logic [RUN_W-1:0]   r_olen;
    logic               r_olast;

    logic [IDX_W-1:0]   wc_eff;
    logic               hdr_now;
    logic [RUN_W-1:0]   hi_byte;
    logic [RUN_W-1:0]   lo_byte;
    logic [RUN_W-1:0]   black_run;
    logic [RUN_W-1:0]   red_run;
    logic [WIDTH_W-1:0] width_clamped;
    logic [WIDTH_W-1:0] w_eff;
    logic [1:0]         sel;
    logic [RUN_W-1:0]   run_cur;
    logic [WIDTH_W-1:0] col_ext;
    logic [WIDTH_W-1:0] avail;
    logic [RUN_W-1:0]   seg_len;
    logic [WIDTH_W-1:0] col_sum;
    logic               later_empty;
    logic [COLOR_W-1:0] seg_color;
    logic               out_free;

    assign hi_byte = i_data_word[15:8];
    assign lo_byte = i_data_word[7:0];
    assign wc_eff  = i_start_image ? '0 : r_wc;
    assign hdr_now = wc_eff < IDX_W'(HEADER_WORDS);

    assign black_run = r_bshift[3] ? '0 : (lo_byte >> r_bshift[2:0]);
    assign red_run   = r_rbits[3] ? lo_byte : (lo_byte & ~(8'hFF << r_rbits[2:0]));

    always_comb begin
        if (i_data_word < WORD_W'(MIN_WIDTH)) begin
            width_clamped = W_MIN;
        end else if (i_data_word > WORD_W'(MAX_WIDTH)) begin
            width_clamped = W_MAX;
        end else begin
            width_clamped = i_data_word[WIDTH_W-1:0];
        end
    end

    // a width never set reads as the minimum
    assign w_eff = (r_width < W_MIN) ? W_MIN : r_width;

    // pick the first run still pending: white, then black, then red
    always_comb begin
        if (r_run[0] != '0) begin
            sel         = 2'd0;
            seg_color   = COLOR_WHITE;
            later_empty = (r_run[1] == '0) && (r_run[2] == '0);
        end else if (r_run[1] != '0) begin
            sel         = 2'd1;
            seg_color   = COLOR_BLACK;
            later_empty = (r_run[2] == '0);
        end else begin
            sel         = 2'd2;
            seg_color   = COLOR_RED;
            later_empty = 1'b1;
        end
    end

    assign run_cur = r_run[sel];
    assign col_ext = {1'b0, r_col};
    assign avail   = (col_ext < w_eff) ? (w_eff - col_ext) : WIDTH_W'(1);
    assign seg_len = (WIDTH_W'(run_cur) < avail) ? run_cur : avail[RUN_W-1:0];
    assign col_sum = col_ext + WIDTH_W'(seg_len);

    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        o_sts          = '0;
        o_sts.hdr_next = hdr_now;
        o_sts.any_run  = (r_run[0] != '0) || (r_run[1] != '0) || (r_run[2] != '0);
        o_sts.seg_last = (run_cur == seg_len) && later_empty;
        o_sts.out_free = out_free;
    end

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc     <= '0;
            r_width  <= '0;
            r_bshift <= '0;
            r_rbits  <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_run[0] <= '0;
            r_run[1] <= '0;
            r_run[2] <= '0;
        end else if (i_cmd.load) begin
            if (i_start_image) begin
                r_col <= '0;
                r_row <= '0;
            end
            if (hdr_now) begin
                r_wc     <= wc_eff + IDX_W'(1);
                r_run[0] <= '0;
                r_run[1] <= '0;
                r_run[2] <= '0;
                if (wc_eff == HDR_WIDTH) begin
                    r_width <= width_clamped;
                end
                if (wc_eff == HDR_RUN_WIDTHS) begin
                    r_bshift <= (lo_byte > 8'd15) ? 4'd15 : lo_byte[3:0];
                end
                if (wc_eff == HDR_RED_WIDTH) begin
                    r_rbits <= (hi_byte > 8'd15) ? 4'd15 : hi_byte[3:0];
                end
            end else begin
                r_wc     <= wc_eff;
                r_run[0] <= hi_byte;
                r_run[1] <= black_run;
                r_run[2] <= red_run;
            end
        end else if (i_cmd.emit_seg) begin
            r_run[sel] <= run_cur - seg_len;
            // wrap to the next row at the image width, holding the last row
            if (col_sum >= w_eff) begin
                r_col <= '0;
                if (r_row != MAX_ROW) begin
                    r_row <= r_row + POS_W'(1);
                end
            end else begin
                r_col <= col_sum[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hidx <= wc_eff;
            r_word <= i_data_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_hdr || i_cmd.emit_seg) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_hdr) begin
            r_okind  <= KIND_HEADER;
            r_ohidx  <= r_hidx;
            r_oword  <= r_word;
            r_ocolor <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_olen   <= '0;
            r_olast  <= 1'b1;
        end else if (i_cmd.emit_seg) begin
            r_okind  <= KIND_SEGMENT;
            r_ohidx  <= '0;
            r_oword  <= '0;
            r_ocolor <= seg_color;
            r_ox     <= r_col;
            r_oy     <= r_row;
            r_olen   <= seg_len;
            r_olast  <= o_sts.seg_last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_kind         = r_okind;
    assign o_header_index = r_ohidx;
    assign o_header_value = r_oword;
    assign o_pixel_color  = r_ocolor;
    assign o_seg_x        = r_ox;
    assign o_seg_y        = r_oy;
    assign o_seg_len      = r_olen;
    assign o_last         = r_olast;

endmodule

`default_nettype wire

>>> sv/rle_tricolor_raster_decoder.sv
// Top level of the run-length decoder for three-color raster images.
`default_nettype none

// Takes an image stream one 16-bit word per request (first stream byte in bits
// 15..8). The first seven words of an image are header words; each is echoed as
// one result with kind 0 and last set. Word 3 sets the image width, clamped to
// MIN_WIDTH..MAX_WIDTH; the low byte of word 5 sets the black shift and the high
// byte of word 6 the red field width. Every later word carries a white, a black
// and a red run that are painted in raster order, wrapping at the image width,
// and each run comes out as one segment per row it touches (kind 1); the row
// saturates at 1023. A word whose runs are all empty gives no result. Raising
// start_image with a word restarts header parsing at position 0,0 with that word.
// One request is in work at a time: a header word is loaded and then echoed, and
// a body word is loaded and then painted one segment at a time, or dropped when
// all its runs are empty, because the shared column/row update unit produces one
// segment per cycle while the output register is not stalled. No clearing pass
// follows reset.
module rle_tricolor_raster_decoder #(
    parameter int MAX_WIDTH = rtd_pkg::DEF_MAX_WIDTH,
    parameter int MIN_WIDTH = rtd_pkg::DEF_MIN_WIDTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [rtd_pkg::WORD_W-1:0]          i_data_word,
    input  wire                                 i_start_image,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic                                o_kind,
    output logic [rtd_pkg::IDX_W-1:0]           o_header_index,
    output logic [rtd_pkg::WORD_W-1:0]          o_header_value,
    output logic [rtd_pkg::COLOR_W-1:0]         o_pixel_color,
    output logic [rtd_pkg::POS_W-1:0]           o_seg_x,
    output logic [rtd_pkg::POS_W-1:0]           o_seg_y,
    output logic [rtd_pkg::RUN_W-1:0]           o_seg_len,
    output logic                                o_last
);
    import rtd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequence load, header echo and one segment per cycle while the output is free
    rtd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // hold header settings and raster position, build each result
    rtd_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MIN_WIDTH (MIN_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_data_word    (i_data_word),
        .i_start_image  (i_start_image),
        .i_stall        (i_stall),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_header_index (o_header_index),
        .o_header_value (o_header_value),
        .o_pixel_color  (o_pixel_color),
        .o_seg_x        (o_seg_x),
        .o_seg_y        (o_seg_y),
        .o_seg_len      (o_seg_len),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

>>> sv/rtd_checker.sv
// Port-level assertions for the raster decoder, bound to the top level.
`default_nettype none

module rtd_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 o_valid,
    input wire                                 i_stall,
    input wire                                 o_kind,
    input wire  [rtd_pkg::IDX_W-1:0]           o_header_index,
    input wire  [rtd_pkg::COLOR_W-1:0]         o_pixel_color,
    input wire  [rtd_pkg::RUN_W-1:0]           o_seg_len,
    input wire  [rtd_pkg::POS_W-1:0]           o_seg_x,
    input wire                                 o_last
);
    import rtd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_seg_x) && $stable(o_seg_len)
            && $stable(o_last))
        else $error("stalled result changed");

    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_HEADER) |-> o_last
            && (o_header_index < IDX_W'(HEADER_WORDS)))
        else $error("header result malformed");

    a_seg_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_SEGMENT) |-> (o_seg_len != '0)
            && (o_pixel_color != '0) && (o_header_index == '0))
        else $error("segment result malformed");

endmodule

bind rle_tricolor_raster_decoder rtd_checker u_rtd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_kind         (o_kind),
    .o_header_index (o_header_index),
    .o_pixel_color  (o_pixel_color),
    .o_seg_len      (o_seg_len),
    .o_seg_x        (o_seg_x),
    .o_last         (o_last)
);

`default_nettype wire

>>> tb/sv/rtd_raster_checker.sv
// Checker for the run-length raster decoder: predicts every request's results and compares them.
`timescale 1ns / 1ps

module rtd_raster_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_word_valid,
    input  wire                          i_word_stall,
    input  wire  [rtd_pkg::WORD_W-1:0]   i_data_word,
    input  wire                          i_start_image,
    input  wire                          i_res_valid,
    input  wire                          i_res_stall,
    input  wire                          i_kind,
    input  wire  [rtd_pkg::IDX_W-1:0]    i_header_index,
    input  wire  [rtd_pkg::WORD_W-1:0]   i_header_value,
    input  wire  [rtd_pkg::COLOR_W-1:0]  i_pixel_color,
    input  wire  [rtd_pkg::POS_W-1:0]    i_seg_x,
    input  wire  [rtd_pkg::POS_W-1:0]    i_seg_y,
    input  wire  [rtd_pkg::RUN_W-1:0]    i_seg_len,
    input  wire                          i_last,
    output int                           o_mismatches,
    output int                           o_outstanding,
    output int                           o_headers,
    output int                           o_segments,
    output logic                         o_row_saturated
);
    import rtd_pkg::*;

    localparam int MAX_PIECES  = 27;
    localparam int FIELD_MAX   = 15;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    index;
        logic [WORD_W-1:0]   value;
        logic [COLOR_W-1:0]  color;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [RUN_W-1:0]    len;
        logic                last;
    } t_piece;

    t_piece             decoded_q[$];
    logic [IDX_W-1:0]   words_seen;
    logic [WIDTH_W-1:0] img_width;
    logic [3:0]         blk_shift;
    logic [3:0]         red_width;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    int                 n_bad;
    int                 n_hdr;
    int                 n_seg;
    logic               hit_last_row;

    task automatic report(input string msg);
        if (n_bad < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
        n_bad++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) report($sformatf("%s expected %0d, got %0d", name, want, got));
    endtask

    function automatic logic [WIDTH_W-1:0] fit_width(input int w);
        if (w < DEF_MIN_WIDTH) return WIDTH_W'(DEF_MIN_WIDTH);
        if (w > DEF_MAX_WIDTH) return WIDTH_W'(DEF_MAX_WIDTH);
        return WIDTH_W'(w);
    endfunction

    // Split one run into row segments, wrapping at the image width.
    function automatic void paint(input int run, input logic [COLOR_W-1:0] color,
                                  inout int made);
        int     span;
        int     avail;
        int     len;
        int     nxt;
        t_piece p;
        span = fit_width(img_width);
        while (run > 0 && made < MAX_PIECES) begin
            avail = (int'(col) < span) ? span - int'(col) : 1;
            len   = (run < avail) ? run : avail;
            p       = '0;
            p.kind  = KIND_SEGMENT;
            p.color = color;
            p.x     = col;
            p.y     = row;
            p.len   = RUN_W'(len);
            decoded_q.push_back(p);
            made++;
            run -= len;
            nxt = int'(col) + len;
            if (nxt >= span) begin
                col = '0;
                if (row != MAX_ROW) row++;
            end else begin
                col = POS_W'(nxt);
            end
        end
    endfunction

    function automatic void decode_word(input logic [WORD_W-1:0] word, input logic restart);
        logic [7:0] hi;
        logic [7:0] lo;
        int         made;
        int         black;
        int         red;
        t_piece     p;
        hi   = word[15:8];
        lo   = word[7:0];
        made = 0;
        if (restart) begin
            words_seen = '0;
            col        = '0;
            row        = '0;
        end
        if (words_seen < HEADER_WORDS) begin
            case (words_seen)
                HDR_WIDTH:      img_width = fit_width(word);
                HDR_RUN_WIDTHS: blk_shift = (lo > FIELD_MAX) ? 4'(FIELD_MAX) : lo[3:0];
                HDR_RED_WIDTH:  red_width = (hi > FIELD_MAX) ? 4'(FIELD_MAX) : hi[3:0];
                default: ;
            endcase
            p       = '0;
            p.kind  = KIND_HEADER;
            p.index = words_seen;
            p.value = word;
            p.last  = 1'b1;
            decoded_q.push_back(p);
            words_seen++;
        end else begin
            black = (blk_shift < 8) ? int'(lo >> blk_shift) : 0;
            red   = (red_width < 8) ? (int'(lo) & ((1 << red_width) - 1)) : int'(lo);
            paint(int'(hi), COLOR_WHITE, made);
            paint(black, COLOR_BLACK, made);
            paint(red, COLOR_RED, made);
            if (made > 0) decoded_q[decoded_q.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_piece got;
        t_piece want;
        if (!i_rst_n) begin
            decoded_q.delete();
            words_seen   = '0;
            img_width    = '0;
            blk_shift    = '0;
            red_width    = '0;
            col          = '0;
            row          = '0;
            n_bad        = 0;
            n_hdr        = 0;
            n_seg        = 0;
            hit_last_row = 1'b0;
        end else begin
            // Retire the result first: it can only belong to an earlier request.
            if (i_res_valid && !i_res_stall) begin
                got = {i_kind, i_header_index, i_header_value, i_pixel_color,
                       i_seg_x, i_seg_y, i_seg_len, i_last};
                if (got.kind == KIND_SEGMENT) n_seg++;
                else n_hdr++;
                if (got.kind == KIND_SEGMENT && got.y == MAX_ROW) hit_last_row = 1'b1;
                if (decoded_q.size() == 0) begin
                    report($sformatf("result with nothing due: kind %0d idx %0d x %0d y %0d",
                                     got.kind, got.index, got.x, got.y));
                end else begin
                    want = decoded_q.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("header_index", want.index, got.index);
                    check_field("header_value", want.value, got.value);
                    check_field("pixel_color", want.color, got.color);
                    check_field("seg_x", want.x, got.x);
                    check_field("seg_y", want.y, got.y);
                    check_field("seg_len", want.len, got.len);
                    check_field("last", want.last, got.last);
                end
            end
            if (i_word_valid && !i_word_stall) decode_word(i_data_word, i_start_image);
        end
        o_mismatches    <= n_bad;
        o_outstanding   <= decoded_q.size();
        o_headers       <= n_hdr;
        o_segments      <= n_seg;
        o_row_saturated <= hit_last_row;
    end

endmodule

>>> tb/sv/rle_tricolor_raster_decoder_test.sv
// Top of the raster decoder testbench: clock, reset, word stimulus, result backpressure, verdict.
`timescale 1ns / 1ps

module rle_tricolor_raster_decoder_test;
    import rtd_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int TARGET_WORDS  = 320;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int OVERFLOW_BODY = 50;

    logic                clk;
    logic                rst_n;

    // request side
    logic                word_valid;
    logic                word_stall;
    logic [WORD_W-1:0]   data_word;
    logic                start_image;

    // result side
    logic                seg_valid;
    logic                seg_stall;
    logic                res_kind;
    logic [IDX_W-1:0]    res_header_index;
    logic [WORD_W-1:0]   res_header_value;
    logic [COLOR_W-1:0]  res_pixel_color;
    logic [POS_W-1:0]    res_seg_x;
    logic [POS_W-1:0]    res_seg_y;
    logic [RUN_W-1:0]    res_seg_len;
    logic                res_last;

    // checker status
    int                  mismatches;
    int                  pieces_due;
    int                  headers_seen;
    int                  segments_seen;
    logic                row_saturated;

    // stimulus bookkeeping
    bit                  no_idle;
    bit                  hold_off_req;
    int                  words_sent;
    int                  images_started;
    int                  cycle_count;

    rle_tricolor_raster_decoder u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (word_valid),
        .o_stall        (word_stall),
        .i_data_word    (data_word),
        .i_start_image  (start_image),
        .o_valid        (seg_valid),
        .i_stall        (seg_stall),
        .o_kind         (res_kind),
        .o_header_index (res_header_index),
        .o_header_value (res_header_value),
        .o_pixel_color  (res_pixel_color),
        .o_seg_x        (res_seg_x),
        .o_seg_y        (res_seg_y),
        .o_seg_len      (res_seg_len),
        .o_last         (res_last)
    );

    rtd_raster_checker u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_word_valid    (word_valid),
        .i_word_stall    (word_stall),
        .i_data_word     (data_word),
        .i_start_image   (start_image),
        .i_res_valid     (seg_valid),
        .i_res_stall     (seg_stall),
        .i_kind          (res_kind),
        .i_header_index  (res_header_index),
        .i_header_value  (res_header_value),
        .i_pixel_color   (res_pixel_color),
        .i_seg_x         (res_seg_x),
        .i_seg_y         (res_seg_y),
        .i_seg_len       (res_seg_len),
        .i_last          (res_last),
        .o_mismatches    (mismatches),
        .o_outstanding   (pieces_due),
        .o_headers       (headers_seen),
        .o_segments      (segments_seen),
        .o_row_saturated (row_saturated)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the decoder hangs or loses results.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("rle_tricolor_raster_decoder_test: FAIL");
        $finish;
    end

    // Result side: stall a random number of cycles before taking each result.
    // On request from the stimulus, hold off for a long stretch so the decoder
    // backs up and stalls its input.
    initial begin : result_sink
        int pause;
        int held;
        seg_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                seg_stall <= 1'b1;
                for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
            end else begin
                pause = no_idle ? 0 : $urandom_range(0, 4);
                if (pause > 0) begin
                    seg_stall <= 1'b1;
                    repeat (pause) @(posedge clk);
                end
            end
            seg_stall <= 1'b0;
            do @(posedge clk); while (!(seg_valid && !seg_stall));
        end
    end

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic s);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_valid  <= 1'b1;
        data_word   <= w;
        start_image <= s;
        do @(posedge clk); while (!(word_valid && !word_stall));
        words_sent++;
        if (s) images_started++;
    endtask

    // Mostly narrow images so runs wrap often; now and then out-of-range widths.
    function automatic logic [WORD_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return WORD_W'($urandom_range(0, DEF_MIN_WIDTH - 1));
            1:       return WORD_W'($urandom_range(97, DEF_MAX_WIDTH));
            2:       return WORD_W'($urandom_range(DEF_MAX_WIDTH + 1, 65535));
            3:       return WORD_W'($urandom_range(0, 65535));
            default: return WORD_W'($urandom_range(DEF_MIN_WIDTH, 96));
        endcase
    endfunction

    // Shift / red-width byte: mostly usable, sometimes past 8 or saturating.
    function automatic logic [7:0] pick_setting_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8, 15));
            1:       return 8'($urandom_range(16, 255));
            default: return 8'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_body_word();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return {8'h00, 8'($urandom_range(0, 255))};
            2, 3, 4: return {8'($urandom_range(0, 40)), 8'($urandom_range(0, 255))};
            default: return WORD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // One image: header (possibly cut short) followed by body words, with an
    // occasional stray restart inside the body.
    task automatic send_image(input logic lead_start, input int head_len, input int body_len);
        logic [WORD_W-1:0] w;
        for (int i = 0; i < head_len; i++) begin
            case (i)
                HDR_WIDTH:      w = pick_width();
                HDR_RUN_WIDTHS: w = {8'($urandom_range(0, 255)), pick_setting_byte()};
                HDR_RED_WIDTH:  w = {pick_setting_byte(), 8'($urandom_range(0, 255))};
                default:        w = WORD_W'($urandom_range(0, 65535));
            endcase
            send_word(w, (i == 0) && lead_start);
        end
        for (int j = 0; j < body_len; j++)
            send_word(pick_body_word(), $urandom_range(0, 39) == 0);
    endtask

    initial begin : stimulus
        rst_n          = 1'b0;
        word_valid     = 1'b0;
        data_word      = '0;
        start_image    = 1'b0;
        no_idle        = 1'b0;
        hold_off_req   = 1'b0;
        words_sent     = 0;
        images_started = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Image straight out of reset, no start flag: header parsing starts at word 0.
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h5A3C, 1'b0);
        send_word(16'h0000, 1'b0);   // width 0 clamps up to the minimum
        send_word(16'h00C8, 1'b0);
        send_word(16'hFFFF, 1'b0);   // shift saturates at 15: black runs vanish; high byte ignored
        send_word(16'hFF00, 1'b0);   // red width saturates: red keeps the whole low byte
        send_word(16'h0000, 1'b0);   // all runs empty, no result
        send_word(16'hFFFF, 1'b0);   // long white and red runs wrapping over many rows
        send_word(16'h00A5, 1'b0);   // red only

        // Broken header, then restart with the maximum width.
        send_word(16'h1111, 1'b1);
        send_word(16'h2222, 1'b0);
        send_word(16'hABCD, 1'b1);
        send_word(16'h0001, 1'b0);
        send_word(16'h0002, 1'b0);
        send_word(16'hFFFF, 1'b0);   // width above the maximum clamps down
        send_word(16'h0300, 1'b0);
        send_word(16'hEE03, 1'b0);   // shift 3
        send_word(16'h04FF, 1'b0);   // red width 4
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0108, 1'b0);

        // Narrow image with maximum runs: rows run past 1023 and saturate, and
        // words hit the per-request segment cap. Hold off the result side once.
        no_idle = 1'b1;
        send_word(16'h0000, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0040, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'h0800, 1'b0);
        hold_off_req = 1'b1;
        for (int n = 0; n < OVERFLOW_BODY; n++) begin
            if (n == OVERFLOW_BODY / 2) no_idle = 1'b0;
            send_word(16'hFFFF, 1'b0);
        end

        // Random images: mostly well-formed, some cut short or without a start.
        while (words_sent < TARGET_WORDS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            send_image($urandom_range(0, 7) != 0,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : HEADER_WORDS,
                       $urandom_range(3, 20));
        end
        word_valid <= 1'b0;

        // Drain: wait for every due result, then watch for strays.
        @(posedge clk);
        while (pieces_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d data words over %0d image starts: %0d header echoes, %0d segments",
                 words_sent, images_started, headers_seen, segments_seen);
        $display("Bottom row saturation %s; %0d field mismatches",
                 row_saturated ? "reached" : "not reached", mismatches);
        if (mismatches == 0) begin
            $display("rle_tricolor_raster_decoder_test: PASS");
        end else begin
            $display("rle_tricolor_raster_decoder_test: FAIL");
        end
        $finish;
    end

endmodule
